>>> rtl/dsl_pkg.sv
// ============================================================================
// dsl_pkg: shared types and constants for the DSL token lexer
// Result word layout, scan modes, token type and error codes, keyword table.
// ============================================================================
package dsl_pkg;

    typedef enum logic [3:0] {
        M_IDLE,
        M_COLON,
        M_LBRACK,
        M_EQUALS,
        M_SLASH,
        M_LINECOM,
        M_BLOCK,
        M_STAR,
        M_NUMBER,
        M_IDENT,
        M_CODE,
        M_CODEBR
    } scan_mode_t;

    // token types
    localparam logic [4:0] TOK_EOF    = 5'd0;
    localparam logic [4:0] TOK_ERR    = 5'd1;
    localparam logic [4:0] TOK_LBRACE = 5'd2;
    localparam logic [4:0] TOK_RBRACE = 5'd3;
    localparam logic [4:0] TOK_LPAREN = 5'd4;
    localparam logic [4:0] TOK_RPAREN = 5'd5;
    localparam logic [4:0] TOK_COLON  = 5'd6;
    localparam logic [4:0] TOK_DCOLON = 5'd7;
    localparam logic [4:0] TOK_SEMI   = 5'd8;
    localparam logic [4:0] TOK_STAR   = 5'd9;
    localparam logic [4:0] TOK_COMMA  = 5'd10;
    localparam logic [4:0] TOK_LBRACK = 5'd11;
    localparam logic [4:0] TOK_RBRACK = 5'd12;
    localparam logic [4:0] TOK_ARROW  = 5'd13;
    localparam logic [4:0] TOK_NUMBER = 5'd14;
    localparam logic [4:0] TOK_CODE   = 5'd15;
    localparam logic [4:0] TOK_IDENT  = 5'd16;
    localparam logic [4:0] TOK_KW0    = 5'd17;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_ARROW   = 3'd1;
    localparam logic [2:0] ERR_SLASH   = 3'd2;
    localparam logic [2:0] ERR_COMMENT = 3'd3;
    localparam logic [2:0] ERR_CODE    = 3'd4;
    localparam logic [2:0] ERR_START   = 3'd5;

    localparam int NUM_KW = 9;
    localparam logic [3:0] IDENT_LEN_MAX = 4'd15;

    // keywords, right-justified; char i of a keyword of length L sits at byte L-1-i
    localparam logic [79:0] KW_TEXT [NUM_KW] = '{
        80'("type"), 80'("conversion"), 80'("register"), 80'("operation"),
        80'("costs"), 80'("impl"), 80'("tile"), 80'("as"), 80'("runtime")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd4, 4'd10, 4'd8, 4'd9, 4'd5, 4'd4, 4'd4, 4'd2, 4'd7
    };

    typedef struct packed {
        logic        kind;
        logic [4:0]  token_type;
        logic [7:0]  text_byte;
        logic [2:0]  error_code;
        logic [23:0] start_line;
        logic        last;
    } result_t;

    // up to three result words for one character
    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    count;
    } lex_out_t;

    // drop keyword candidates that do not match character c at position len
    function automatic logic [NUM_KW-1:0] kw_step(logic [NUM_KW-1:0] cand,
                                                   logic [3:0] len,
                                                   logic [7:0] c);
        logic [NUM_KW-1:0] r;
        logic [79:0]       sh;
        r = cand;
        for (int k = 0; k < NUM_KW; k++)
        begin
            sh = '0;
            if (len >= KW_LEN[k])
            begin
                r[k] = 1'b0;
            end
            else
            begin
                sh = KW_TEXT[k] >> (8 * (int'(KW_LEN[k]) - 1 - int'(len)));
                if (sh[7:0] != c)
                begin
                    r[k] = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // first surviving keyword of exactly the seen length, else plain identifier
    function automatic logic [4:0] kw_type(logic [NUM_KW-1:0] cand, logic [3:0] len);
        logic [4:0] r;
        r = TOK_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (cand[k] && len == KW_LEN[k])
            begin
                r = TOK_KW0 + 5'(k);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/dsl_char_if.sv
// ============================================================================
// dsl_char_if: character input channel
// One character byte per word, valid/ready handshake.
// ============================================================================
interface dsl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

>>> rtl/dsl_tok_if.sv
// ============================================================================
// dsl_tok_if: token result channel
// One result word per handshake: text byte, token done, error or end of file.
// ============================================================================
interface dsl_tok_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [4:0]  token_type;
    logic [7:0]  text_byte;
    logic [2:0]  error_code;
    logic [23:0] start_line;
    logic        last;

    modport source (output valid, output kind, output token_type, output text_byte,
                    output error_code, output start_line, output last,
                    input ready);
    modport sink   (input valid, input kind, input token_type, input text_byte,
                    input error_code, input start_line, input last,
                    output ready);
endinterface

>>> rtl/dsl_token_lexer.sv
// ============================================================================
// dsl_token_lexer: streaming lexer for a small table-description language
// Character stream in, token text bytes and token-done words out.
// ============================================================================
// One character is taken per word on chars; byte 0 ends the input. Each
// character yields zero to three result words on tokens (text byte, token
// done, error, end of file), and the last word of a character has last set.
// A character is accepted in the cycle after the previous one was lexed as
// long as it produced at most one word and tokens keeps ready high, so
// steady text runs at one character per clock. A character that produces
// more than one word holds the input until the single-word output port
// has drained a three-entry result register to its last word. Lexing is
// combinational logic from the accepted character into that result
// register. Line numbers count newline bytes, saturate at 2^LINE_BITS-1,
// and appear on start_line truncated or zero-extended to 24 bits.
module dsl_token_lexer #(
    parameter int LINE_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    dsl_char_if.sink          chars,
    dsl_tok_if.source         tokens
);

    dsl_pkg::lex_out_t        lex;
    dsl_pkg::result_t [2:0]   q_reg, q_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic                     fire;
    logic                     pop;

    // pending words: q_reg[0] is on the port, the rest wait behind it
    assign pop         = (cnt_reg != 2'd0) && tokens.ready;
    assign chars.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && tokens.ready);
    assign fire        = chars.valid && chars.ready;

    dsl_lex_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (fire),
        .ch    (chars.ch),
        .lex   (lex)
    );

    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (fire)
        begin
            // queue is empty or its only word leaves this cycle
            q_next   = lex.res;
            cnt_next = lex.count;
        end
        else if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign tokens.valid      = (cnt_reg != 2'd0);
    assign tokens.kind       = q_reg[0].kind;
    assign tokens.token_type = q_reg[0].token_type;
    assign tokens.text_byte  = q_reg[0].text_byte;
    assign tokens.error_code = q_reg[0].error_code;
    assign tokens.start_line = q_reg[0].start_line;
    assign tokens.last       = q_reg[0].last;

endmodule

>>> rtl/dsl_lex_core.sv
// ============================================================================
// dsl_lex_core: scanner state and per-character next-state logic
// Holds mode, line counters and keyword tracking; produces up to three words.
// ============================================================================
module dsl_lex_core #(
    parameter int LINE_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         ch,
    output dsl_pkg::lex_out_t  lex
);

    dsl_pkg::scan_mode_t             mode_reg, mode_next;
    logic [LINE_BITS-1:0]            line_reg, line_next;
    logic [LINE_BITS-1:0]            tline_reg, tline_next;
    logic [dsl_pkg::NUM_KW-1:0]      cand_reg, cand_next;
    logic [3:0]                      len_reg, len_next;

    logic [1:0]                      n;
    dsl_pkg::result_t [2:0]          res;
    logic                            do_fresh;

    function automatic logic [23:0] to_out(logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+23:0] w;
        w = {24'd0, v};
        return w[23:0];
    endfunction

    function automatic dsl_pkg::result_t mk(logic kind, logic [4:0] tt, logic [7:0] b,
                                            logic [2:0] err, logic [LINE_BITS-1:0] ln);
        dsl_pkg::result_t r;
        r.kind       = kind;
        r.token_type = tt;
        r.text_byte  = b;
        r.error_code = err;
        r.start_line = to_out(ln);
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c inside {" ", [8'd9:8'd13]};
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        tline_next = tline_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        n          = 2'd0;
        res        = '0;
        do_fresh   = 1'b0;

        line_next = line_reg;
        if (ch == 8'h0A && line_reg != '1)
        begin
            line_next = line_reg + LINE_BITS'(1);
        end

        case (mode_reg)
            dsl_pkg::M_COLON:
            begin
                if (ch == ":")
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_DCOLON, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                    mode_next = dsl_pkg::M_IDLE;
                end
                else
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_COLON, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            dsl_pkg::M_LBRACK:
            begin
                if (ch == "[")
                begin
                    mode_next = dsl_pkg::M_CODE;
                end
                else
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_LBRACK, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            dsl_pkg::M_EQUALS:
            begin
                if (ch == ">")
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_ARROW, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                end
                else
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_ERR, 8'd0, dsl_pkg::ERR_ARROW, tline_next);
                    n = n + 2'd1;
                    if (ch == 8'd0)
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_EOF, 8'd0, dsl_pkg::ERR_NONE, line_next);
                        n = n + 2'd1;
                    end
                end
                mode_next = dsl_pkg::M_IDLE;
            end
            dsl_pkg::M_SLASH:
            begin
                if (ch == "/")
                begin
                    mode_next = dsl_pkg::M_LINECOM;
                end
                else if (ch == "*")
                begin
                    mode_next = dsl_pkg::M_BLOCK;
                end
                else
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_ERR, 8'd0, dsl_pkg::ERR_SLASH, tline_next);
                    n = n + 2'd1;
                    if (ch == 8'd0)
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_EOF, 8'd0, dsl_pkg::ERR_NONE, line_next);
                        n = n + 2'd1;
                    end
                    mode_next = dsl_pkg::M_IDLE;
                end
            end
            dsl_pkg::M_LINECOM:
            begin
                if (ch == 8'h0A)
                begin
                    mode_next = dsl_pkg::M_IDLE;
                end
                else if (ch == 8'd0)
                begin
                    do_fresh = 1'b1;
                end
            end
            dsl_pkg::M_BLOCK, dsl_pkg::M_STAR:
            begin
                if (ch == 8'd0)
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_ERR, 8'd0, dsl_pkg::ERR_COMMENT, tline_next);
                    n = n + 2'd1;
                    res[n] = mk(1'b1, dsl_pkg::TOK_EOF, 8'd0, dsl_pkg::ERR_NONE, line_next);
                    n = n + 2'd1;
                    mode_next = dsl_pkg::M_IDLE;
                end
                else if (ch == "/" && mode_reg == dsl_pkg::M_STAR)
                begin
                    mode_next = dsl_pkg::M_IDLE;
                end
                else if (ch == "*")
                begin
                    mode_next = dsl_pkg::M_STAR;
                end
                else
                begin
                    mode_next = dsl_pkg::M_BLOCK;
                end
            end
            dsl_pkg::M_NUMBER:
            begin
                if (is_digit(ch))
                begin
                    res[n] = mk(1'b0, dsl_pkg::TOK_NUMBER, ch, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                end
                else
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_NUMBER, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            dsl_pkg::M_IDENT:
            begin
                if (is_alpha(ch) || is_digit(ch) || ch == "_")
                begin
                    cand_next = dsl_pkg::kw_step(cand_reg, len_reg, ch);
                    if (len_reg != dsl_pkg::IDENT_LEN_MAX)
                    begin
                        len_next = len_reg + 4'd1;
                    end
                    res[n] = mk(1'b0, dsl_pkg::TOK_IDENT, ch, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                end
                else
                begin
                    res[n] = mk(1'b1, dsl_pkg::kw_type(cand_reg, len_reg), 8'd0,
                                dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            dsl_pkg::M_CODEBR:
            begin
                if (ch == "]")
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_CODE, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                    mode_next = dsl_pkg::M_IDLE;
                end
                else
                begin
                    // lone bracket inside code is plain text
                    res[n] = mk(1'b0, dsl_pkg::TOK_CODE, "]", dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                    if (ch == 8'd0)
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_ERR, 8'd0, dsl_pkg::ERR_CODE, tline_next);
                        n = n + 2'd1;
                        res[n] = mk(1'b1, dsl_pkg::TOK_EOF, 8'd0, dsl_pkg::ERR_NONE, line_next);
                        n = n + 2'd1;
                        mode_next = dsl_pkg::M_IDLE;
                    end
                    else
                    begin
                        res[n] = mk(1'b0, dsl_pkg::TOK_CODE, ch, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                        mode_next = dsl_pkg::M_CODE;
                    end
                end
            end
            dsl_pkg::M_CODE:
            begin
                if (ch == 8'd0)
                begin
                    res[n] = mk(1'b1, dsl_pkg::TOK_ERR, 8'd0, dsl_pkg::ERR_CODE, tline_next);
                    n = n + 2'd1;
                    res[n] = mk(1'b1, dsl_pkg::TOK_EOF, 8'd0, dsl_pkg::ERR_NONE, line_next);
                    n = n + 2'd1;
                    mode_next = dsl_pkg::M_IDLE;
                end
                else if (ch == "]")
                begin
                    mode_next = dsl_pkg::M_CODEBR;
                end
                else
                begin
                    res[n] = mk(1'b0, dsl_pkg::TOK_CODE, ch, dsl_pkg::ERR_NONE, tline_next);
                    n = n + 2'd1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // lex the character from a token boundary
        if (do_fresh)
        begin
            mode_next = dsl_pkg::M_IDLE;
            if (ch == 8'd0)
            begin
                res[n] = mk(1'b1, dsl_pkg::TOK_EOF, 8'd0, dsl_pkg::ERR_NONE, line_next);
                n = n + 2'd1;
            end
            else if (!is_space(ch))
            begin
                tline_next = line_next;
                case (ch)
                    "{":
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_LBRACE, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                    end
                    "}":
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_RBRACE, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                    end
                    "(":
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_LPAREN, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                    end
                    ")":
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_RPAREN, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                    end
                    ";":
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_SEMI, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                    end
                    "*":
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_STAR, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                    end
                    ",":
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_COMMA, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                    end
                    "]":
                    begin
                        res[n] = mk(1'b1, dsl_pkg::TOK_RBRACK, 8'd0, dsl_pkg::ERR_NONE, tline_next);
                        n = n + 2'd1;
                    end
                    ":": mode_next = dsl_pkg::M_COLON;
                    "[": mode_next = dsl_pkg::M_LBRACK;
                    "=": mode_next = dsl_pkg::M_EQUALS;
                    "/": mode_next = dsl_pkg::M_SLASH;
                    default:
                    begin
                        if (is_digit(ch))
                        begin
                            mode_next = dsl_pkg::M_NUMBER;
                            res[n] = mk(1'b0, dsl_pkg::TOK_NUMBER, ch, dsl_pkg::ERR_NONE,
                                        tline_next);
                            n = n + 2'd1;
                        end
                        else if (is_alpha(ch))
                        begin
                            mode_next = dsl_pkg::M_IDENT;
                            cand_next = dsl_pkg::kw_step('1, 4'd0, ch);
                            len_next  = 4'd1;
                            res[n] = mk(1'b0, dsl_pkg::TOK_IDENT, ch, dsl_pkg::ERR_NONE,
                                        tline_next);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            res[n] = mk(1'b1, dsl_pkg::TOK_ERR, 8'd0, dsl_pkg::ERR_START,
                                        tline_next);
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            res[i].last = (2'(i) + 2'd1 == n);
        end
    end

    assign lex.res   = res;
    assign lex.count = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dsl_pkg::M_IDLE;
            line_reg  <= LINE_BITS'(1);
            tline_reg <= LINE_BITS'(1);
            cand_reg  <= '0;
            len_reg   <= 4'd0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            tline_reg <= tline_next;
            cand_reg  <= cand_next;
            len_reg   <= len_next;
        end
    end

endmodule

>>> rtl/dsl_lex_checker.sv
// ============================================================================
// dsl_lex_checker: port-level checks for the DSL token lexer
// Bound to the top level; watches the token channel only.
// ============================================================================
module dsl_lex_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        t_valid,
    input logic        t_ready,
    input logic        t_kind,
    input logic [4:0]  t_type,
    input logic [7:0]  t_byte,
    input logic [2:0]  t_err,
    input logic [23:0] t_line,
    input logic        t_last
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid && !t_ready |=> t_valid && $stable(t_kind) && $stable(t_type)
            && $stable(t_byte) && $stable(t_err) && $stable(t_line) && $stable(t_last))
        else $error("token word changed while stalled");

    // error code present exactly on error words
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid |-> ((t_type == dsl_pkg::TOK_ERR) == (t_err != dsl_pkg::ERR_NONE))
            && ((t_type != dsl_pkg::TOK_ERR) || t_kind))
        else $error("error code and token type disagree");

    // text bytes belong to number, code or identifier and are never zero
    a_text: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid && !t_kind |-> t_byte != 8'd0 && (t_type == dsl_pkg::TOK_NUMBER
            || t_type == dsl_pkg::TOK_CODE || t_type == dsl_pkg::TOK_IDENT))
        else $error("bad text byte word");

    // end of file closes the words of its character
    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid && t_kind && t_type == dsl_pkg::TOK_EOF |-> t_last && t_byte == 8'd0)
        else $error("end of file word not last");

    // token-done words carry no text byte
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid && t_kind && t_type != dsl_pkg::TOK_EOF |-> t_byte == 8'd0)
        else $error("token done word carries a text byte");

endmodule

bind dsl_token_lexer dsl_lex_checker u_dsl_lex_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .t_valid (tokens.valid),
    .t_ready (tokens.ready),
    .t_kind  (tokens.kind),
    .t_type  (tokens.token_type),
    .t_byte  (tokens.text_byte),
    .t_err   (tokens.error_code),
    .t_line  (tokens.start_line),
    .t_last  (tokens.last)
);
